[rtl/core/i2cm_pkg.sv]
// Shared types, constants and the pin-step decode for the I2C master byte engine.
// Used by i2cm_seq, i2c_master_byte_engine and tb_top; depends on nothing else.
`default_nettype none

package i2cm_pkg;

   // Command codes, also the encoding of the active command register.
   typedef enum logic [3:0] {
      CMD_NONE       = 4'd0,
      CMD_START      = 4'd1,
      CMD_STOP       = 4'd2,
      CMD_WRITE_BYTE = 4'd3,
      CMD_WRITE_ADDR = 4'd4,
      CMD_READ_BYTE  = 4'd5,
      CMD_ACK        = 4'd6,
      CMD_NACK       = 4'd7,
      CMD_WAIT_ACK   = 4'd8
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_DELAY_TICKS = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_index_type;

   localparam logic [15:0] DELAY_TICKS_RESET = 16'd10;
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;
   localparam logic [3:0]  CMD_FIRST         = 4'd1;
   localparam logic [3:0]  CMD_LAST          = 4'd8;
   localparam int          BYTE_BITS         = 8;

   // One input item as held in the input register.
   typedef struct packed {
      logic [3:0] command;
      logic [7:0] data_byte;
      logic [6:0] slave_address;
      logic       read_not_write;
      logic       sda_level;
   } item_type;

   // One result item.
   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       engine_busy;
      logic       command_done;
      logic       ack_seen;
      logic [7:0] received_byte;
      logic       line_held_low;
   } rsp_type;

   // Line drives at the start of a pin step; drv is {scl, sda}.
   function automatic logic [1:0] begin_drives(input cmd_type    cmd,
                                               input logic [2:0] phase,
                                               input logic [3:0] bit_idx,
                                               input logic [7:0] shift,
                                               input logic [1:0] drv);
      logic [1:0] res;
      res = drv;
      unique case (cmd)
         CMD_START: begin
            priority case (phase)
               3'd0:    res[0] = 1'b1;
               3'd1:    res[1] = 1'b1;
               3'd2:    res[0] = 1'b0;
               default: res[1] = 1'b0;
            endcase
         end
         CMD_STOP: begin
            priority case (phase)
               3'd0:    res[0] = 1'b0;
               3'd1:    res[1] = 1'b1;
               3'd2:    res[0] = 1'b1;
               default: res[1] = 1'b0;
            endcase
         end
         CMD_WRITE_BYTE, CMD_WRITE_ADDR: begin
            if (bit_idx < 4'(BYTE_BITS)) begin
               priority case (phase)
                  3'd0:    res[0] = shift[3'd7 - bit_idx[2:0]];
                  3'd1:    res[1] = 1'b1;
                  default: res[1] = 1'b0;
               endcase
            end else if (phase == 3'd0) begin
               res = 2'b11;
            end else begin
               res[1] = 1'b0;
            end
         end
         CMD_READ_BYTE, CMD_NACK: begin
            priority case (phase)
               3'd0:    res[0] = 1'b1;
               3'd1:    res[1] = 1'b1;
               default: res[1] = 1'b0;
            endcase
         end
         CMD_ACK: begin
            priority case (phase)
               3'd0:    res[0] = 1'b0;
               3'd1:    res[1] = 1'b1;
               3'd2:    res[1] = 1'b0;
               default: res[0] = 1'b1;
            endcase
         end
         CMD_WAIT_ACK: begin
            if (phase == 3'd0) begin
               res = 2'b11;
            end else if (phase == 3'd2) begin
               res[1] = 1'b0;
            end
         end
         default: res = drv;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/core/i2cm_seq.sv]
// Bus sequencer: holds the command state and works out one tick per enabled cycle.
// Depends on i2cm_pkg for the command codes, item and result types.
`default_nettype none

module i2cm_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               tick,
   input  wire i2cm_pkg::item_type item,
   input  wire logic [15:0]        delay_ticks,
   input  wire logic [15:0]        ack_timeout,
   output      i2cm_pkg::rsp_type  result
);

   i2cm_pkg::cmd_type cmd_ff, cmd_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] ival_ff, ival_in;
   logic [15:0] poll_ff, poll_in;
   logic [1:0]  drv_ff, drv_in;
   logic        ack_ff, ack_in;
   logic [7:0]  rx_ff, rx_in;

   logic              start;
   logic [15:0]       reload;
   i2cm_pkg::cmd_type a_cmd;
   logic [2:0]        a_phase, e_phase;
   logic [3:0]        a_bit, e_bit;
   logic [7:0]        a_shift;
   logic [15:0]       a_ival, a_poll;
   logic [1:0]        a_drv;
   logic              busy, done, fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= i2cm_pkg::CMD_NONE;
         phase_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         ival_ff  <= '0;
         poll_ff  <= '0;
         drv_ff   <= 2'b11;
         ack_ff   <= 1'b0;
         rx_ff    <= '0;
      end else if (tick) begin
         cmd_ff   <= cmd_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         ival_ff  <= ival_in;
         poll_ff  <= poll_in;
         drv_ff   <= drv_in;
         ack_ff   <= ack_in;
         rx_ff    <= rx_in;
      end
   end

   always_comb begin
      // A new command is taken only while idle; unknown codes are dropped.
      start  = (cmd_ff == i2cm_pkg::CMD_NONE) && (item.command >= i2cm_pkg::CMD_FIRST)
               && (item.command <= i2cm_pkg::CMD_LAST);
      reload = (delay_ticks == '0) ? '0 : delay_ticks - 16'd1;

      a_cmd   = start ? i2cm_pkg::cmd_type'(item.command) : cmd_ff;
      a_phase = start ? 3'd0 : phase_ff;
      a_bit   = start ? 4'd0 : bit_ff;
      a_shift = shift_ff;
      if (start && a_cmd == i2cm_pkg::CMD_WRITE_BYTE) begin
         a_shift = item.data_byte;
      end else if (start && a_cmd == i2cm_pkg::CMD_WRITE_ADDR) begin
         a_shift = {item.slave_address, item.read_not_write};
      end
      a_poll = (start && a_cmd == i2cm_pkg::CMD_WAIT_ACK) ? ack_timeout : poll_ff;
      a_drv  = start ? i2cm_pkg::begin_drives(a_cmd, 3'd0, 4'd0, a_shift, drv_ff) : drv_ff;
      a_ival = start ? reload : ival_ff;

      cmd_in   = a_cmd;
      phase_in = a_phase;
      bit_in   = a_bit;
      shift_in = a_shift;
      ival_in  = a_ival;
      poll_in  = a_poll;
      drv_in   = a_drv;
      ack_in   = ack_ff;
      rx_in    = rx_ff;
      busy     = 1'b0;
      done     = 1'b0;
      fin      = 1'b0;
      e_phase  = a_phase + 3'd1;
      e_bit    = a_bit;

      if (a_cmd != i2cm_pkg::CMD_NONE) begin
         busy = 1'b1;
         if (a_cmd == i2cm_pkg::CMD_WAIT_ACK && a_phase == 3'd1) begin
            // Polling the slave: one poll per tick until SDA low or budget spent.
            if (!item.sda_level || a_poll == '0) begin
               ack_in   = !item.sda_level && (a_poll != '0);
               phase_in = 3'd2;
               drv_in   = i2cm_pkg::begin_drives(a_cmd, 3'd2, a_bit, a_shift, a_drv);
               ival_in  = reload;
            end else begin
               poll_in = a_poll - 16'd1;
            end
         end else if (a_ival != '0) begin
            ival_in = a_ival - 16'd1;
         end else begin
            unique case (a_cmd)
               i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP, i2cm_pkg::CMD_ACK:
                  fin = e_phase > 3'd3;
               i2cm_pkg::CMD_NACK, i2cm_pkg::CMD_WAIT_ACK:
                  fin = e_phase > 3'd2;
               i2cm_pkg::CMD_WRITE_BYTE, i2cm_pkg::CMD_WRITE_ADDR: begin
                  if (a_bit >= 4'(i2cm_pkg::BYTE_BITS)) begin
                     // Ack check: sampled at the end of the released step.
                     if (a_phase == 3'd0) begin
                        ack_in = !item.sda_level;
                     end
                     fin = e_phase > 3'd1;
                  end else if (e_phase > 3'd2) begin
                     e_phase = 3'd0;
                     e_bit   = a_bit + 4'd1;
                  end
               end
               i2cm_pkg::CMD_READ_BYTE: begin
                  if (a_phase == 3'd1) begin
                     rx_in = {rx_ff[6:0], item.sda_level};
                  end
                  if (e_phase > 3'd2) begin
                     e_phase = 3'd1;
                     e_bit   = a_bit + 4'd1;
                     fin     = e_bit >= 4'(i2cm_pkg::BYTE_BITS);
                  end
               end
               default: fin = 1'b1;
            endcase

            if (fin) begin
               done     = 1'b1;
               cmd_in   = i2cm_pkg::CMD_NONE;
               phase_in = 3'd0;
               bit_in   = 4'd0;
            end else begin
               phase_in = e_phase;
               bit_in   = e_bit;
               if (!(a_cmd == i2cm_pkg::CMD_WAIT_ACK && e_phase == 3'd1)) begin
                  drv_in  = i2cm_pkg::begin_drives(a_cmd, e_phase, e_bit, a_shift, a_drv);
                  ival_in = reload;
               end
            end
         end
      end

      result.scl_drive     = a_drv[1];
      result.sda_drive     = a_drv[0];
      result.engine_busy   = busy;
      result.command_done  = done;
      result.ack_seen      = ack_in;
      result.received_byte = rx_in;
      result.line_held_low = !item.sda_level;
   end

endmodule

`default_nettype wire

[rtl/core/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine: input register, sequencer, result register.
// Depends on i2cm_pkg and i2cm_seq.
`default_nettype none

// Usage
// Each item on the req_ channel is one tick of the bus sequencer. It carries the
// sampled SDA level and, while the engine is idle, a command (start, stop, write
// byte, write address, read byte, ack, nack, wait for ack). Every accepted item
// produces exactly one item on the rsp_ channel with the SCL/SDA drives for that
// tick, busy and done flags, the last ack status and the read shift register.
// An accepted item waits in the input register, is worked out by the sequencer as
// it moves into the result register, and is offered on rsp_ from there.
// Throughput: one item per cycle while rsp_ready is high. The tick logic is a single
// pass from the input register into the sequencer state and the result register.
// When the receiver stalls, the result register holds its item, the input
// register fills, and req_ready drops until rsp_ready returns.
// The csr_ port writes delay_ticks (index 0, reset 10) and ack_timeout (index 1,
// reset 1000); write them only while no item is in flight.
// Reset empties both registers, releases SCL and SDA high and returns the
// sequencer to idle with the ack flag and read byte cleared.

module i2c_master_byte_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [3:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [6:0]  req_slave_address,
   input  wire logic        req_read_not_write,
   input  wire logic        req_sda_level,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_scl_drive,
   output      logic        rsp_sda_drive,
   output      logic        rsp_engine_busy,
   output      logic        rsp_command_done,
   output      logic        rsp_ack_seen,
   output      logic [7:0]  rsp_received_byte,
   output      logic        rsp_line_held_low,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data
);

   logic               in_valid_ff;
   i2cm_pkg::item_type item_ff, item_in;
   logic               out_valid_ff;
   i2cm_pkg::rsp_type  rsp_ff;
   i2cm_pkg::rsp_type  step_rsp;
   logic [15:0]        delay_ff;
   logic [15:0]        timeout_ff;
   logic               advance;

   // The held item moves on whenever the result register is empty or being taken.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign item_in = '{command:        req_command,
                      data_byte:      req_data_byte,
                      slave_address:  req_slave_address,
                      read_not_write: req_read_not_write,
                      sda_level:      req_sda_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= i2cm_pkg::DELAY_TICKS_RESET;
         timeout_ff <= i2cm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (i2cm_pkg::csr_index_type'(csr_index))
            i2cm_pkg::CSR_DELAY_TICKS: delay_ff   <= csr_write_data;
            i2cm_pkg::CSR_ACK_TIMEOUT: timeout_ff <= csr_write_data;
            default:                   delay_ff   <= delay_ff;
         endcase
      end
   end

   // The sequencer state only moves when a tick is handed to the result register.
   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .tick        (advance),
      .item        (item_ff),
      .delay_ticks (delay_ff),
      .ack_timeout (timeout_ff),
      .result      (step_rsp)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_scl_drive     = rsp_ff.scl_drive;
   assign rsp_sda_drive     = rsp_ff.sda_drive;
   assign rsp_engine_busy   = rsp_ff.engine_busy;
   assign rsp_command_done  = rsp_ff.command_done;
   assign rsp_ack_seen      = rsp_ff.ack_seen;
   assign rsp_received_byte = rsp_ff.received_byte;
   assign rsp_line_held_low = rsp_ff.line_held_low;

   // A held item that cannot move on must still be there next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held item lost from the input register");

   // Every tick worked out lands in the result register as a valid item.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid && rsp_engine_busy == $past(step_rsp.engine_busy)))
      else $error("worked tick not presented on the result channel");

   // A finished command is always reported on a busy tick.
   assert property (@(posedge clock) disable iff (reset)
      (advance && step_rsp.command_done) |=> rsp_engine_busy)
      else $error("command done reported outside a busy tick");

   // Input is refused only while an item is held.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff)
      else $error("input refused with the input register empty");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the I2C master byte engine: directed and random bus ticks.
// Depends on i2cm_pkg for the item, result and code types, and on i2c_master_byte_engine.
`timescale 1ns / 1ps

module tb_top;
   import i2cm_pkg::*;

   // Number of codes the four-bit command field can carry; codes above CMD_LAST are unknown.
   localparam int          CMD_CODES   = 16;
   localparam logic [15:0] REG_MAX     = 16'hFFFF;
   localparam int          GAP_MAX     = 19;
   localparam int          RANDOM_TICKS = 1000;
   localparam int          REPORT_MAX  = 10;

   // Every input of the block has a known value from time zero.
   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic [3:0]  req_command        = CMD_NONE;
   logic [7:0]  req_data_byte      = '0;
   logic [6:0]  req_slave_address  = '0;
   logic        req_read_not_write = 1'b0;
   logic        req_sda_level      = 1'b1;
   logic        rsp_ready          = 1'b0;
   logic        csr_write_enable   = 1'b0;
   logic        csr_index          = CSR_DELAY_TICKS;
   logic [15:0] csr_write_data     = '0;

   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_scl_drive;
   logic        rsp_sda_drive;
   logic        rsp_engine_busy;
   logic        rsp_command_done;
   logic        rsp_ack_seen;
   logic [7:0]  rsp_received_byte;
   logic        rsp_line_held_low;

   i2c_master_byte_engine dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_data_byte      (req_data_byte),
      .req_slave_address  (req_slave_address),
      .req_read_not_write (req_read_not_write),
      .req_sda_level      (req_sda_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scl_drive      (rsp_scl_drive),
      .rsp_sda_drive      (rsp_sda_drive),
      .rsp_engine_busy    (rsp_engine_busy),
      .rsp_command_done   (rsp_command_done),
      .rsp_ack_seen       (rsp_ack_seen),
      .rsp_received_byte  (rsp_received_byte),
      .rsp_line_held_low  (rsp_line_held_low),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // Upper bounds of the per-item idling on each side; zero gives a stretch with no idling.
   int req_gap_max   = GAP_MAX;
   int rsp_stall_max = GAP_MAX;

   int ticks_sent    = 0;
   int results_seen  = 0;
   int error_count   = 0;

   // Results the bus model expects, oldest first.
   rsp_type expected_ticks[$];

   // Our own copy of the sequencer: configuration, then the state of the command in hand.
   logic [15:0] cfg_delay;
   logic [15:0] cfg_timeout;
   cmd_type     bus_cmd;
   logic [2:0]  bus_phase;
   logic [3:0]  bus_bit;
   logic [7:0]  bus_shift;
   logic [15:0] bus_hold;
   logic [15:0] bus_polls;
   logic [1:0]  bus_lines;   // {scl, sda}, 1 means released
   logic        bus_ack;
   logic [7:0]  bus_rx;

   task automatic reset_bus_model();
      cfg_delay   = DELAY_TICKS_RESET;
      cfg_timeout = ACK_TIMEOUT_RESET;
      bus_cmd     = CMD_NONE;
      bus_phase   = '0;
      bus_bit     = '0;
      bus_shift   = '0;
      bus_hold    = '0;
      bus_polls   = '0;
      bus_lines   = 2'b11;
      bus_ack     = 1'b0;
      bus_rx      = '0;
   endtask

   // Applies the pin levels at the start of the current step and reloads the hold counter.
   task automatic load_step();
      case (bus_cmd)
         CMD_START: begin
            if (bus_phase == 3'd0) bus_lines[0] = 1'b1;
            else if (bus_phase == 3'd1) bus_lines[1] = 1'b1;
            else if (bus_phase == 3'd2) bus_lines[0] = 1'b0;
            else bus_lines[1] = 1'b0;
         end
         CMD_STOP: begin
            if (bus_phase == 3'd0) bus_lines[0] = 1'b0;
            else if (bus_phase == 3'd1) bus_lines[1] = 1'b1;
            else if (bus_phase == 3'd2) bus_lines[0] = 1'b1;
            else bus_lines[1] = 1'b0;
         end
         CMD_WRITE_BYTE, CMD_WRITE_ADDR: begin
            if (bus_bit < 4'd8) begin
               if (bus_phase == 3'd0) bus_lines[0] = bus_shift[3'd7 - bus_bit[2:0]];
               else bus_lines[1] = (bus_phase == 3'd1);
            end else if (bus_phase == 3'd0) begin
               bus_lines = 2'b11;
            end else begin
               bus_lines[1] = 1'b0;
            end
         end
         CMD_READ_BYTE, CMD_NACK: begin
            if (bus_phase == 3'd0) bus_lines[0] = 1'b1;
            else bus_lines[1] = (bus_phase == 3'd1);
         end
         CMD_ACK: begin
            if (bus_phase == 3'd0) bus_lines[0] = 1'b0;
            else if (bus_phase == 3'd1) bus_lines[1] = 1'b1;
            else if (bus_phase == 3'd2) bus_lines[1] = 1'b0;
            else bus_lines[0] = 1'b1;
         end
         CMD_WAIT_ACK: begin
            if (bus_phase == 3'd0) bus_lines = 2'b11;
            else if (bus_phase == 3'd2) bus_lines[1] = 1'b0;
         end
         default: ;
      endcase
      bus_hold = (cfg_delay == 16'd0) ? 16'd0 : cfg_delay - 16'd1;
   endtask

   // End of a step's hold: samples SDA where the step calls for it and moves on.
   task automatic close_step(input logic sda, output logic seq_end);
      seq_end = 1'b0;
      case (bus_cmd)
         CMD_START, CMD_STOP, CMD_ACK: begin
            bus_phase = bus_phase + 3'd1;
            seq_end   = (bus_phase > 3'd3);
         end
         CMD_NACK, CMD_WAIT_ACK: begin
            bus_phase = bus_phase + 3'd1;
            seq_end   = (bus_phase > 3'd2);
         end
         CMD_WRITE_BYTE, CMD_WRITE_ADDR: begin
            if (bus_bit >= 4'd8) begin
               // The ack bit is taken at the end of the released-SCL step.
               if (bus_phase == 3'd0) bus_ack = !sda;
               bus_phase = bus_phase + 3'd1;
               seq_end   = (bus_phase > 3'd1);
            end else begin
               bus_phase = bus_phase + 3'd1;
               if (bus_phase > 3'd2) begin
                  bus_phase = 3'd0;
                  bus_bit   = bus_bit + 4'd1;
               end
            end
         end
         CMD_READ_BYTE: begin
            if (bus_phase == 3'd1) bus_rx = {bus_rx[6:0], sda};
            bus_phase = bus_phase + 3'd1;
            if (bus_phase > 3'd2) begin
               bus_phase = 3'd1;
               bus_bit   = bus_bit + 4'd1;
               seq_end   = (bus_bit >= 4'd8);
            end
         end
         default: seq_end = 1'b1;
      endcase
   endtask

   // One bus tick: works out the result item that the given input item causes.
   task automatic bus_tick(input item_type it, output rsp_type res);
      logic [1:0] drv_now;
      logic       seq_end;
      res = '0;
      // A command is taken only while idle; unknown codes and busy-time commands are dropped.
      if (bus_cmd == CMD_NONE && it.command >= CMD_FIRST && it.command <= CMD_LAST) begin
         bus_cmd   = cmd_type'(it.command);
         bus_phase = 3'd0;
         bus_bit   = 4'd0;
         if (bus_cmd == CMD_WRITE_BYTE) bus_shift = it.data_byte;
         else if (bus_cmd == CMD_WRITE_ADDR) bus_shift = {it.slave_address, it.read_not_write};
         if (bus_cmd == CMD_WAIT_ACK) bus_polls = cfg_timeout;
         load_step();
      end
      drv_now = bus_lines;
      if (bus_cmd != CMD_NONE) begin
         res.engine_busy = 1'b1;
         if (bus_cmd == CMD_WAIT_ACK && bus_phase == 3'd1) begin
            // Polling: leave on a low SDA or when the budget is spent; a zero budget never acks.
            if (!it.sda_level || bus_polls == 16'd0) begin
               bus_ack   = !it.sda_level && (bus_polls != 16'd0);
               bus_phase = 3'd2;
               load_step();
            end else begin
               bus_polls = bus_polls - 16'd1;
            end
         end else if (bus_hold != 16'd0) begin
            bus_hold = bus_hold - 16'd1;
         end else begin
            close_step(it.sda_level, seq_end);
            if (seq_end) begin
               res.command_done = 1'b1;
               bus_cmd   = CMD_NONE;
               bus_phase = 3'd0;
               bus_bit   = 4'd0;
            end else if (!(bus_cmd == CMD_WAIT_ACK && bus_phase == 3'd1)) begin
               load_step();
            end
         end
      end
      res.scl_drive     = drv_now[1];
      res.sda_drive     = drv_now[0];
      res.ack_seen      = bus_ack;
      res.received_byte = bus_rx;
      res.line_held_low = !it.sda_level;
   endtask

   // Offers one item after a random gap and holds it until the block takes it.
   task automatic send_tick(input item_type it);
      int      gap;
      rsp_type want;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= it.command;
      req_data_byte      <= it.data_byte;
      req_slave_address  <= it.slave_address;
      req_read_not_write <= it.read_not_write;
      req_sda_level      <= it.sda_level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bus_tick(it, want);
      expected_ticks.push_back(want);
      ticks_sent++;
   endtask

   // An item with random payload; SDA is high with the given percentage.
   function automatic item_type random_tick(input logic [3:0] cmd, input int sda_pct);
      item_type it;
      it.command        = cmd;
      it.data_byte      = 8'($urandom_range(0, 255));
      it.slave_address  = 7'($urandom_range(0, 127));
      it.read_not_write = 1'($urandom_range(0, 1));
      it.sda_level      = ($urandom_range(0, 99) < sda_pct);
      return it;
   endfunction

   // Issues one command and keeps the bus ticking until our model says the engine is idle.
   // With noisy set, commands are also thrown at the engine while it is busy.
   task automatic run_command(input logic [3:0] cmd, input logic [7:0] data,
                              input logic [6:0] addr, input logic rnw,
                              input int sda_pct, input bit noisy);
      item_type it;
      it                = random_tick(cmd, sda_pct);
      it.data_byte      = data;
      it.slave_address  = addr;
      it.read_not_write = rnw;
      send_tick(it);
      while (bus_cmd != CMD_NONE) begin
         it = random_tick(CMD_NONE, sda_pct);
         if (noisy && $urandom_range(0, 3) == 0) begin
            it.command = 4'($urandom_range(0, CMD_CODES - 1));
         end
         send_tick(it);
      end
   endtask

   // Waits until every result is in, lets the pipeline settle, then writes both registers.
   task automatic set_config(input logic [15:0] delay, input logic [15:0] timeout);
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DELAY_TICKS;
      csr_write_data   <= delay;
      @(posedge clock);
      csr_index        <= CSR_ACK_TIMEOUT;
      csr_write_data   <= timeout;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_delay   = delay;
      cfg_timeout = timeout;
   endtask

   function automatic int pick_sda_pct();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 10;
         2:       return 50;
         3:       return 90;
         4:       return 100;
         default: return $urandom_range(0, 100);
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------------------------------

   // The register values out of reset: a start and a stop with the default hold time.
   task automatic test_reset_values();
      run_command(CMD_START, 8'h00, 7'h00, 1'b0, 50, 1'b0);
      run_command(CMD_STOP, 8'h00, 7'h00, 1'b0, 50, 1'b0);
   endtask

   // Write byte with the slave acking, with it not acking, and with a mixed pattern.
   task automatic test_write_byte();
      set_config(16'd1, 16'd8);
      run_command(CMD_WRITE_BYTE, 8'hFF, 7'h00, 1'b0, 0, 1'b0);
      run_command(CMD_WRITE_BYTE, 8'h00, 7'h00, 1'b0, 100, 1'b0);
      run_command(CMD_WRITE_BYTE, 8'h5A, 7'h00, 1'b0, 50, 1'b1);
   endtask

   // Address byte at both ends of the address range and both directions.
   task automatic test_write_address();
      run_command(CMD_WRITE_ADDR, 8'h00, 7'h7F, 1'b1, 0, 1'b0);
      run_command(CMD_WRITE_ADDR, 8'hFF, 7'h00, 1'b0, 100, 1'b0);
      run_command(CMD_WRITE_ADDR, 8'h00, 7'h2A, 1'b1, 50, 1'b0);
   endtask

   // Read byte with SDA held high, held low and random.
   task automatic test_read_byte();
      set_config(16'd2, 16'd8);
      run_command(CMD_READ_BYTE, 8'h00, 7'h00, 1'b0, 100, 1'b0);
      run_command(CMD_READ_BYTE, 8'h00, 7'h00, 1'b0, 0, 1'b0);
      run_command(CMD_READ_BYTE, 8'h00, 7'h00, 1'b0, 50, 1'b0);
   endtask

   task automatic test_ack_nack();
      set_config(16'd3, 16'd8);
      run_command(CMD_ACK, 8'h00, 7'h00, 1'b0, 50, 1'b0);
      run_command(CMD_NACK, 8'h00, 7'h00, 1'b0, 50, 1'b0);
   endtask

   // Wait for ack: a zero budget never acks, an immediate ack, a timeout, and a late ack.
   task automatic test_wait_ack();
      set_config(16'd1, 16'd0);
      run_command(CMD_WAIT_ACK, 8'h00, 7'h00, 1'b0, 0, 1'b0);
      set_config(16'd1, 16'd6);
      run_command(CMD_WAIT_ACK, 8'h00, 7'h00, 1'b0, 0, 1'b0);
      run_command(CMD_WAIT_ACK, 8'h00, 7'h00, 1'b0, 100, 1'b0);
      run_command(CMD_WAIT_ACK, 8'h00, 7'h00, 1'b0, 80, 1'b0);
   endtask

   // Unknown codes while idle, and any command while a sequence runs, must be dropped.
   task automatic test_ignored_commands();
      for (int c = CMD_LAST + 1; c < CMD_CODES; c++) send_tick(random_tick(4'(c), 50));
      run_command(CMD_START, 8'h00, 7'h00, 1'b0, 50, 1'b1);
      send_tick(random_tick(CMD_NONE, 50));
   endtask

   // A zero hold time behaves as one tick per step.
   task automatic test_zero_delay();
      set_config(16'd0, 16'd4);
      run_command(CMD_START, 8'h00, 7'h00, 1'b0, 50, 1'b0);
      run_command(CMD_WRITE_BYTE, 8'hC3, 7'h00, 1'b0, 50, 1'b0);
      run_command(CMD_READ_BYTE, 8'h00, 7'h00, 1'b0, 50, 1'b0);
      run_command(CMD_WAIT_ACK, 8'h00, 7'h00, 1'b0, 90, 1'b0);
      run_command(CMD_STOP, 8'h00, 7'h00, 1'b0, 50, 1'b0);
   endtask

   // A long hold time, then the largest poll budget with the slave answering early.
   // The hold time is kept moderate so the item count stays in budget; no idling here.
   task automatic test_extreme_settings();
      req_gap_max   = 0;
      rsp_stall_max = 0;
      set_config(16'd40, 16'd1);
      run_command(CMD_NACK, 8'h00, 7'h00, 1'b0, 50, 1'b0);
      set_config(16'd1, REG_MAX);
      run_command(CMD_WAIT_ACK, 8'h00, 7'h00, 1'b0, 0, 1'b0);
      run_command(CMD_WAIT_ACK, 8'h00, 7'h00, 1'b0, 90, 1'b0);
      req_gap_max   = GAP_MAX;
      rsp_stall_max = GAP_MAX;
   endtask

   // Mostly well-formed transfers (start, address, data bytes, stop) with random content,
   // mixed with lone commands, unknown codes and idle ticks. Settings and idling change often.
   task automatic test_random_traffic();
      int         stop_at;
      int         next_cfg;
      int         pick;
      int         nbytes;
      logic [15:0] delay;
      logic [15:0] timeout;
      logic       rnw;
      stop_at  = ticks_sent + RANDOM_TICKS;
      next_cfg = ticks_sent;
      while (ticks_sent < stop_at) begin
         if (ticks_sent >= next_cfg) begin
            case ($urandom_range(0, 5))
               0:       delay = 16'd0;
               1, 2:    delay = 16'd1;
               3:       delay = 16'd2;
               4:       delay = 16'd3;
               default: delay = 16'($urandom_range(4, 6));
            endcase
            case ($urandom_range(0, 3))
               0:       timeout = 16'd0;
               1:       timeout = 16'($urandom_range(1, 4));
               default: timeout = 16'($urandom_range(5, 30));
            endcase
            set_config(delay, timeout);
            next_cfg = ticks_sent + 150;
         end
         req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
         rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            rnw = 1'($urandom_range(0, 1));
            run_command(CMD_START, 8'h00, 7'h00, 1'b0, pick_sda_pct(), 1'b0);
            run_command(CMD_WRITE_ADDR, 8'h00, 7'($urandom_range(0, 127)), rnw,
                        pick_sda_pct(), $urandom_range(0, 3) == 0);
            nbytes = $urandom_range(1, 3);
            for (int n = 0; n < nbytes; n++) begin
               if (rnw) begin
                  run_command(CMD_READ_BYTE, 8'h00, 7'h00, 1'b0, pick_sda_pct(), 1'b0);
                  run_command((n == nbytes - 1) ? CMD_NACK : CMD_ACK, 8'h00, 7'h00, 1'b0,
                              pick_sda_pct(), 1'b0);
               end else begin
                  run_command(CMD_WRITE_BYTE, 8'($urandom_range(0, 255)), 7'h00, 1'b0,
                              pick_sda_pct(), $urandom_range(0, 3) == 0);
               end
            end
            run_command(CMD_STOP, 8'h00, 7'h00, 1'b0, pick_sda_pct(), 1'b0);
         end else if (pick < 88) begin
            run_command(4'($urandom_range(CMD_FIRST, CMD_LAST)), 8'($urandom_range(0, 255)),
                        7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                        pick_sda_pct(), $urandom_range(0, 1) == 1);
         end else if (pick < 94) begin
            send_tick(random_tick(4'($urandom_range(CMD_LAST + 1, CMD_CODES - 1)), 50));
         end else begin
            repeat ($urandom_range(1, 5)) send_tick(random_tick(CMD_NONE, 50));
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Result checker: takes each result item after a random stall and compares it, field by
   // field, with the oldest expectation.
   // ---------------------------------------------------------------------------------------
   initial begin
      int      stall;
      rsp_type got;
      rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.scl_drive     = rsp_scl_drive;
         got.sda_drive     = rsp_sda_drive;
         got.engine_busy   = rsp_engine_busy;
         got.command_done  = rsp_command_done;
         got.ack_seen      = rsp_ack_seen;
         got.received_byte = rsp_received_byte;
         got.line_held_low = rsp_line_held_low;
         results_seen++;
         if (expected_ticks.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("Result %0d arrived with no item outstanding", results_seen);
         end else begin
            want = expected_ticks.pop_front();
            if (got.scl_drive !== want.scl_drive || got.sda_drive !== want.sda_drive ||
                got.engine_busy !== want.engine_busy ||
                got.command_done !== want.command_done ||
                got.ack_seen !== want.ack_seen || got.received_byte !== want.received_byte ||
                got.line_held_low !== want.line_held_low) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("Mismatch on result %0d:", results_seen);
                  $display("  expected scl=%b sda=%b busy=%b done=%b ack=%b rx=%h low=%b",
                           want.scl_drive, want.sda_drive, want.engine_busy,
                           want.command_done, want.ack_seen, want.received_byte,
                           want.line_held_low);
                  $display("  actual   scl=%b sda=%b busy=%b done=%b ack=%b rx=%h low=%b",
                           got.scl_drive, got.sda_drive, got.engine_busy,
                           got.command_done, got.ack_seen, got.received_byte,
                           got.line_held_low);
               end
            end
         end
      end
   end

   // Hard limit on the run, several times the slowest correct run.
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Reset once, then the tests in turn, then drain and report.
   initial begin
      reset_bus_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_write_byte();
      test_write_address();
      test_read_byte();
      test_ack_nack();
      test_wait_ack();
      test_ignored_commands();
      test_zero_delay();
      test_extreme_settings();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      // Anything still outstanding here is a lost result.
      error_count += expected_ticks.size();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_seq.sv
rtl/core/i2c_master_byte_engine.sv
test/tb_top.sv
